[hw/rtl/assert_macros.svh]
// Assertion macros used by the encoder back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every edge out of reset.
`define OPE_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("encoder assertion failed");
// Antecedent implies consequent in the same cycle.
`define OPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder implication failed");
// Antecedent implies consequent in the next cycle.
`define OPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder sequence failed");
`else
`define OPE_ASSERT(label, clk, rst_n, cond)
`define OPE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OPE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/ope_pkg.sv]
// Types and constants of the order-preserving key encoder.
`default_nettype none
package ope_pkg;

    // Request codes
    localparam logic [2:0] REQ_STR_BYTE  = 3'd0;
    localparam logic [2:0] REQ_STR_EMPTY = 3'd1;
    localparam logic [2:0] REQ_U32       = 3'd2;
    localparam logic [2:0] REQ_U64       = 3'd3;
    localparam logic [2:0] REQ_NULL_FST  = 3'd4;
    localparam logic [2:0] REQ_NULL_LST  = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_TAG_STRING    = 3'd0;
    localparam logic [2:0] CFG_TAG_U32       = 3'd1;
    localparam logic [2:0] CFG_TAG_U64       = 3'd2;
    localparam logic [2:0] CFG_TAG_NULL_FST  = 3'd3;
    localparam logic [2:0] CFG_TAG_NULL_LST  = 3'd4;

    // Reset tags
    localparam logic [7:0] RST_TAG_STRING   = 8'd1;
    localparam logic [7:0] RST_TAG_U32      = 8'd2;
    localparam logic [7:0] RST_TAG_U64      = 8'd3;
    localparam logic [7:0] RST_TAG_NULL_FST = 8'd0;
    localparam logic [7:0] RST_TAG_NULL_LST = 8'd6;

    // Encoding bytes
    localparam logic [7:0] KEY_ESCAPE       = 8'h00;
    localparam logic [7:0] KEY_TERM         = 8'h01;
    localparam logic [7:0] KEY_ESCAPED_NULL = 8'hFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // One classified item, as queued between front and back
    typedef struct packed {
        logic        has_tag;
        logic [7:0]  tag;
        logic        has_data;
        logic [2:0]  last_idx;  // index of the most significant data byte
        logic [63:0] data;
        logic        esc;       // data byte is zero and needs the escape byte
        logic        term;      // terminator follows
    } t_desc;

endpackage
`default_nettype wire

[hw/rtl/ope_if.sv]
// Stream interfaces of the encoder: request channel and byte channel.
`default_nettype none
interface ope_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [63:0] payload;
    logic        first_byte;
    logic        last_byte;

    modport source (output valid, req_type, payload, first_byte, last_byte, input ready);
    modport sink   (input valid, req_type, payload, first_byte, last_byte, output ready);
endinterface

interface ope_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_run;

    modport source (output valid, out_byte, end_of_run, input ready);
    modport sink   (input valid, out_byte, end_of_run, output ready);
endinterface
`default_nettype wire

[hw/rtl/order_preserving_key_encoder.sv]
// Order-preserving key encoder top level: front end, descriptor queue, serialiser.
// The block emits one encoded byte per clock while the sink takes them. An item
// yields one or two bytes for a string byte (two to five with the tag or
// terminator), three for an empty string or null marker, seven for a 32-bit
// value and eleven for a 64-bit value. The byte serialiser in the back end sets
// this rate; the front end keeps accepting requests into a QUEUE_DEPTH-entry
// descriptor queue, while it has room, as the serialiser works, and request
// codes that yield nothing are taken and dropped. Tag registers are written
// through the configuration port at indexes 0 to 4 and should only change
// while the block is idle.
`default_nettype none
module order_preserving_key_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ope_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ope_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ope_in_if.sink                              i_in,
    ope_out_if.source                           o_out
);

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    ope_pkg::t_desc w_desc;
    ope_pkg::t_desc w_head;

    // Classify requests
    ope_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_desc     (w_desc)
    );

    // Decouple front and back
    ope_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_desc),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // Serialise bytes
    ope_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

[hw/rtl/ope_front.sv]
// Front end: tag registers and classification of requests into descriptors.
`default_nettype none
module ope_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ope_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ope_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ope_in_if.sink                             i_in,
    input  wire logic                          i_q_full,
    output      logic                          o_push,
    output      ope_pkg::t_desc                o_desc
);

    logic [7:0] r_tag_string;
    logic [7:0] r_tag_u32;
    logic [7:0] r_tag_u64;
    logic [7:0] r_tag_null_fst;
    logic [7:0] r_tag_null_lst;
    logic       n_known;

    // Write tag registers; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_string   <= ope_pkg::RST_TAG_STRING;
            r_tag_u32      <= ope_pkg::RST_TAG_U32;
            r_tag_u64      <= ope_pkg::RST_TAG_U64;
            r_tag_null_fst <= ope_pkg::RST_TAG_NULL_FST;
            r_tag_null_lst <= ope_pkg::RST_TAG_NULL_LST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ope_pkg::CFG_TAG_STRING:   r_tag_string   <= i_cfg_data;
                ope_pkg::CFG_TAG_U32:      r_tag_u32      <= i_cfg_data;
                ope_pkg::CFG_TAG_U64:      r_tag_u64      <= i_cfg_data;
                ope_pkg::CFG_TAG_NULL_FST: r_tag_null_fst <= i_cfg_data;
                ope_pkg::CFG_TAG_NULL_LST: r_tag_null_lst <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the request beat
    always_comb begin
        o_desc          = '0;
        o_desc.has_tag  = 1'b1;
        o_desc.term     = 1'b1;
        n_known         = 1'b1;
        unique case (i_in.req_type)
            ope_pkg::REQ_STR_BYTE: begin
                o_desc.has_tag  = i_in.first_byte;
                o_desc.tag      = r_tag_string;
                o_desc.has_data = 1'b1;
                o_desc.last_idx = 3'd0;
                o_desc.data     = {56'd0, i_in.payload[7:0]};
                o_desc.esc      = (i_in.payload[7:0] == ope_pkg::KEY_ESCAPE);
                o_desc.term     = i_in.last_byte;
            end
            ope_pkg::REQ_STR_EMPTY: o_desc.tag = r_tag_string;
            ope_pkg::REQ_U32: begin
                o_desc.tag      = r_tag_u32;
                o_desc.has_data = 1'b1;
                o_desc.last_idx = 3'd3;
                o_desc.data     = {32'd0, i_in.payload[31:0]};
            end
            ope_pkg::REQ_U64: begin
                o_desc.tag      = r_tag_u64;
                o_desc.has_data = 1'b1;
                o_desc.last_idx = 3'd7;
                o_desc.data     = i_in.payload;
            end
            ope_pkg::REQ_NULL_FST: o_desc.tag = r_tag_null_fst;
            ope_pkg::REQ_NULL_LST: o_desc.tag = r_tag_null_lst;
            default: n_known = 1'b0;
        endcase
    end

    // Accept while the queue has room; drop codes that yield nothing
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full && n_known;

endmodule
`default_nettype wire

[hw/rtl/ope_queue.sv]
// Descriptor queue between front and back.
`default_nettype none
module ope_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ope_pkg::t_desc i_desc,
    input  wire logic           i_pop,
    output      logic           o_full,
    output      logic           o_empty,
    output      ope_pkg::t_desc o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ope_pkg::t_desc   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Store the pushed descriptor
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/ope_back.sv]
// Back end: serialises one queued descriptor into output bytes.
`default_nettype none
`include "assert_macros.svh"
module ope_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire ope_pkg::t_desc i_head,
    output      logic           o_pop,
    ope_out_if.source           o_out
);

    localparam logic [2:0] P_TAG   = 3'd0;
    localparam logic [2:0] P_DATA  = 3'd1;
    localparam logic [2:0] P_ESC   = 3'd2;
    localparam logic [2:0] P_TERM0 = 3'd3;
    localparam logic [2:0] P_TERM1 = 3'd4;

    logic       r_mid;
    logic [2:0] r_phase;
    logic [2:0] r_cnt;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_eor;

    logic [2:0] n_cur_phase;
    logic [2:0] n_cur_cnt;
    logic [2:0] n_phase;
    logic [2:0] n_cnt;
    logic [7:0] n_byte;
    logic       n_done;
    logic       n_adv;
    logic       n_term_start;

    // Resume a run or start from the head descriptor
    assign n_cur_phase = r_mid ? r_phase : (i_head.has_tag ? P_TAG : P_DATA);
    assign n_cur_cnt   = r_mid ? r_cnt : i_head.last_idx;

    // Pick the byte and the step that follows it
    always_comb begin
        n_byte  = ope_pkg::KEY_ESCAPE;
        n_phase = P_TERM0;
        n_cnt   = n_cur_cnt;
        n_done  = 1'b0;
        unique case (n_cur_phase)
            P_TAG: begin
                n_byte = i_head.tag;
                if (i_head.has_data) begin
                    n_phase = P_DATA;
                end else begin
                    n_done = !i_head.term;
                end
            end
            P_DATA: begin
                n_byte = i_head.data[{n_cur_cnt, 3'b000} +: 8];
                if (n_cur_cnt != 3'd0) begin
                    n_phase = P_DATA;
                    n_cnt   = n_cur_cnt - 3'd1;
                end else if (i_head.esc) begin
                    n_phase = P_ESC;
                end else begin
                    n_done = !i_head.term;
                end
            end
            P_ESC: begin
                n_byte = ope_pkg::KEY_ESCAPED_NULL;
                n_done = !i_head.term;
            end
            P_TERM0: begin
                n_byte  = ope_pkg::KEY_ESCAPE;
                n_phase = P_TERM1;
            end
            P_TERM1: begin
                n_byte = ope_pkg::KEY_TERM;
                n_done = 1'b1;
            end
            default: n_done = 1'b1;
        endcase
    end

    // Produce a byte whenever the queue holds a descriptor and the output register frees up
    assign n_adv = !i_empty && (!r_out_valid || o_out.ready);
    assign o_pop = n_adv && n_done;

    // Mark the first terminator byte leaving the serialiser
    assign n_term_start = n_adv && (n_cur_phase == P_TERM0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_phase     <= P_TAG;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else if (n_adv) begin
            r_out_valid <= 1'b1;
            r_mid       <= !n_done;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_out_byte <= n_byte;
            r_out_eor  <= n_done;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.end_of_run = r_out_eor;

    `OPE_ASSERT_IMP(a_mid_has_head, i_clk, i_rst_n, r_mid, !i_empty)
    `OPE_ASSERT_NXT(a_pop_marks_end, i_clk, i_rst_n, o_pop, r_out_valid && r_out_eor)
    `OPE_ASSERT_NXT(a_term_pair, i_clk, i_rst_n, n_term_start, r_mid && r_phase == P_TERM1)

endmodule
`default_nettype wire
